// ===== rtl/kecd_pkg.sv =====
// Shared types, key codes and character tables for the key event decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package kecd_pkg;

  localparam int ROWS     = 4;
  localparam int COLS     = 10;
  localparam int NUM_KEYS = ROWS * COLS;
  localparam int KEY_W    = $clog2(NUM_KEYS);

  // key indexes (key number minus one)
  localparam logic [6:0] KEY_SYMBOL    = 7'h1E;
  localparam logic [6:0] KEY_ALT       = 7'h14;
  localparam logic [6:0] KEY_CAPS      = 7'h1C;
  localparam logic [6:0] KEY_B         = 7'h19;
  localparam logic [6:0] KEY_BACKSPACE = 7'h1D;

  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] LEVEL_ON       = 8'd127;
  localparam logic [15:0] REPEAT_RESET  = 16'd300;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_PRESS   = 2'd1;
  localparam logic [1:0] ST_RELEASE = 2'd2;

  localparam logic [1:0] REG_REPEAT_ENABLE     = 2'd0;
  localparam logic [1:0] REG_REPEAT_DELAY      = 2'd1;
  localparam logic [1:0] REG_BACKLIGHT_PRESENT = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] event_code;
  } item_t;

  typedef struct packed {
    logic        repeat_enable;
    logic [15:0] repeat_delay;
    logic        backlight_present;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] key_char;
    logic [7:0] brightness;
  } result_t;

  function automatic logic [7:0] letter_char(input logic [KEY_W-1:0] k);
    logic [7:0] c;
    case (k)
      6'd0:  c = "q";
      6'd1:  c = "w";
      6'd2:  c = "e";
      6'd3:  c = "r";
      6'd4:  c = "t";
      6'd5:  c = "y";
      6'd6:  c = "u";
      6'd7:  c = "i";
      6'd8:  c = "o";
      6'd9:  c = "p";
      6'd10: c = "a";
      6'd11: c = "s";
      6'd12: c = "d";
      6'd13: c = "f";
      6'd14: c = "g";
      6'd15: c = "h";
      6'd16: c = "j";
      6'd17: c = "k";
      6'd18: c = "l";
      6'd19: c = 8'h0A;
      6'd21: c = "z";
      6'd22: c = "x";
      6'd23: c = "c";
      6'd24: c = "v";
      6'd25: c = "b";
      6'd26: c = "n";
      6'd27: c = "m";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] symbol_char(input logic [KEY_W-1:0] k);
    logic [7:0] c;
    case (k)
      6'd0:  c = "1";
      6'd1:  c = "2";
      6'd2:  c = "3";
      6'd3:  c = "4";
      6'd4:  c = "5";
      6'd5:  c = "6";
      6'd6:  c = "7";
      6'd7:  c = "8";
      6'd8:  c = "9";
      6'd9:  c = "0";
      6'd10: c = "*";
      6'd11: c = "/";
      6'd12: c = "+";
      6'd13: c = "-";
      6'd14: c = "=";
      6'd15: c = ":";
      6'd16: c = 8'h27;
      6'd17: c = 8'h22;
      6'd18: c = "@";
      6'd21: c = "_";
      6'd22: c = "$";
      6'd23: c = ";";
      6'd24: c = "?";
      6'd25: c = "!";
      6'd26: c = ",";
      6'd27: c = ".";
      6'd30: c = CHAR_SPACE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kecd_in_stage.sv =====
// Input register of the key event decoder: holds one accepted item.
// Depends on kecd_pkg for the item type.
`default_nettype none

module kecd_in_stage
  import kecd_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  wire   take,
  output logic  item_valid,
  output item_t item
);

  logic accept;

  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kecd_core.sv =====
// Decoder state (latches, repeat counter, brightness) and the result register.
// Depends on kecd_pkg for tables, key codes and types.
`default_nettype none

module kecd_core
  import kecd_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  cfg_t    cfg,
  input  wire     item_valid,
  input  item_t   item,
  output logic    take,
  output logic    out_valid,
  input  wire     out_stall,
  output result_t res
);

  logic        symbol_latch, symbol_latch_next;
  logic        caps_latch, caps_latch_next;
  logic        alt_latch, alt_latch_next;
  logic [7:0]  prev_char, prev_char_next;
  logic [7:0]  shown_char, shown_char_next;
  logic        key_held, key_held_next;
  logic [15:0] held_ticks, held_ticks_next;
  logic [7:0]  level, level_next;
  logic        chord_active, chord_active_next;
  logic [1:0]  status_next;
  logic        advance;

  assign advance = !out_valid || !out_stall;
  assign take    = item_valid && advance;

  always_comb begin
    logic             down;
    logic [6:0]       num;
    logic [6:0]       k;
    logic [KEY_W-1:0] kidx;
    logic [7:0]       ch;
    logic [15:0]      ticks;
    logic             done;

    symbol_latch_next = symbol_latch;
    caps_latch_next   = caps_latch;
    alt_latch_next    = alt_latch;
    prev_char_next    = prev_char;
    shown_char_next   = shown_char;
    key_held_next     = key_held;
    held_ticks_next   = held_ticks;
    level_next        = level;
    chord_active_next = chord_active;
    status_next       = ST_NONE;

    down  = item.event_code[7];
    num   = item.event_code[6:0];
    k     = num - 7'd1;
    kidx  = k[KEY_W-1:0];
    ch    = 8'h00;
    ticks = held_ticks;
    done  = 1'b0;

    if (item.opcode == OP_TICK) begin
      if (key_held && held_ticks != 16'hFFFF) begin
        ticks = held_ticks + 16'd1;
      end
      held_ticks_next = ticks;
      if (cfg.repeat_enable && key_held && ticks > cfg.repeat_delay) begin
        if (prev_char == CHAR_SPACE) begin
          // a held space stops repeating
          key_held_next = 1'b0;
        end else begin
          held_ticks_next = 16'd0;
          status_next     = ST_PRESS;
        end
      end
    end else if (num != 7'd0 && k < 7'(NUM_KEYS)) begin
      if (k == KEY_SYMBOL) begin
        symbol_latch_next = !symbol_latch;
      end else if (k == KEY_CAPS) begin
        caps_latch_next = !caps_latch;
        done            = 1'b1;
      end else if (k == KEY_ALT) begin
        alt_latch_next = !alt_latch;
        done           = 1'b1;
      end else if (k == KEY_BACKSPACE) begin
        done            = 1'b1;
        key_held_next   = down;
        held_ticks_next = 16'd0;
        if (down) begin
          shown_char_next = CHAR_BACKSPACE;
          prev_char_next  = CHAR_BACKSPACE;
          status_next     = ST_PRESS;
        end
      end

      if (!done) begin
        if (down) begin
          if (alt_latch && k == KEY_B && cfg.backlight_present) begin
            level_next        = (level != 8'd0) ? 8'd0 : LEVEL_ON;
            chord_active_next = 1'b1;
            done              = 1'b1;
          end
        end else if (chord_active) begin
          // release that ends the brightness chord
          chord_active_next = 1'b0;
          done              = 1'b1;
        end
      end

      if (!done) begin
        if (symbol_latch_next) begin
          ch = symbol_char(kidx);
        end else begin
          ch = letter_char(kidx);
          if (caps_latch && ch >= "a" && ch <= "z") begin
            ch = ch - 8'h20;
          end
        end
        if (symbol_latch_next && ch == CHAR_SPACE) begin
          ch = 8'h00;
        end else if (!symbol_latch_next && prev_char == 8'h00) begin
          ch   = CHAR_SPACE;
          down = 1'b1;
        end
        prev_char_next  = ch;
        shown_char_next = ch;
        key_held_next   = down;
        held_ticks_next = 16'd0;
        status_next     = down ? ST_PRESS : ST_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_latch <= 1'b0;
      caps_latch   <= 1'b0;
      alt_latch    <= 1'b0;
      prev_char    <= 8'h00;
      shown_char   <= 8'h00;
      key_held     <= 1'b0;
      held_ticks   <= 16'd0;
      level        <= 8'd0;
      chord_active <= 1'b0;
    end else if (take) begin
      symbol_latch <= symbol_latch_next;
      caps_latch   <= caps_latch_next;
      alt_latch    <= alt_latch_next;
      prev_char    <= prev_char_next;
      shown_char   <= shown_char_next;
      key_held     <= key_held_next;
      held_ticks   <= held_ticks_next;
      level        <= level_next;
      chord_active <= chord_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.status     <= status_next;
      res.key_char   <= shown_char_next;
      res.brightness <= level_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/key_event_to_char_decoder.sv =====
// Top level of the key event decoder: configuration registers and stage wiring.
// Depends on kecd_pkg, kecd_in_stage and kecd_core.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   input   | in_valid / in_stall    | opcode, event_code
//   output  | out_valid / out_stall  | status, key_char, brightness
//   config  | cfg_we                 | cfg_index, cfg_data
//
// Each item passes through the input register, then the decode logic writes the
// state and result registers.
// One item per cycle is sustained while out_stall stays low.
// Reset is synchronous; it clears the latches, counter, level and both stages.
// A held result stalls the input only once the input register is also full.
`default_nettype none

module key_event_to_char_decoder
  import kecd_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        opcode,
  input  wire [7:0]  event_code,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] status,
  output logic [7:0] key_char,
  output logic [7:0] brightness,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_enable     <= 1'b0;
      cfg.repeat_delay      <= REPEAT_RESET;
      cfg.backlight_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REPEAT_ENABLE:     cfg.repeat_enable     <= cfg_data[0];
        REG_REPEAT_DELAY:      cfg.repeat_delay      <= cfg_data;
        REG_BACKLIGHT_PRESENT: cfg.backlight_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item.opcode     = opcode;
  assign in_item.event_code = event_code;

  kecd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  kecd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign status     = res.status;
  assign key_char   = res.key_char;
  assign brightness = res.brightness;

endmodule

`default_nettype wire
